// ===== design/sta_pkg.sv =====
// shared constants, types and register codes for the timestamp aligner
`default_nettype none
package sta_pkg;

  localparam int NUM_AXES   = 3;
  localparam int TIME_W     = 63;
  localparam int AXIS_IN_W  = 21;
  localparam int AXIS_OUT_W = 25;
  localparam int INTERVAL_W = 30;
  localparam int RESYNC_W   = 40;
  localparam int CFG_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;

  // standard gravity in q16
  localparam logic signed [AXIS_IN_W-1:0] G_Q16 = 21'sd642689;
  localparam int PROD_W = 2 * AXIS_IN_W;

  localparam logic [INTERVAL_W-1:0] DATA_INTERVAL_RST  = 30'd8000000;
  localparam logic [INTERVAL_W-1:0] WINDOW_EPSILON_RST = 30'd1000000;
  localparam logic [RESYNC_W-1:0]   RESYNC_RST         = 40'd5000000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_INTERVAL   = 2'd0,
    CFG_WINDOW_EPSILON  = 2'd1,
    CFG_RESYNC_INTERVAL = 2'd2,
    CFG_PUBLISH_ON_TICK = 2'd3
  } cfg_idx_t;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic [INTERVAL_W-1:0] data_interval;
    logic [INTERVAL_W-1:0] window_epsilon;
    logic [RESYNC_W-1:0]   resync_interval;
    logic                  on_tick;
  } sta_cfg_t;

  typedef struct packed {
    logic              publish;
    logic              load_axes;
    logic              use_latest;
    logic [TIME_W-1:0] stamp;
  } sta_ctrl_t;

endpackage
`default_nettype wire

// ===== design/sta_axis_lane.sv =====
// one axis lane: negate, scale by gravity and round half up
`default_nettype none
module sta_axis_lane
  import sta_pkg::*;
(
  input  wire logic signed [AXIS_IN_W-1:0]  axis_in,
  output logic signed [AXIS_OUT_W-1:0]      axis_out
);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0]   rounded;

  assign prod = axis_in * G_Q16;
  // -a*g + half, then floor by an arithmetic shift of 16
  assign rounded = (PROD_W+1)'(signed'(32768)) - {prod[PROD_W-1], prod};
  // result always fits the output width, so the upper bits are sign copies
  assign axis_out = rounded[AXIS_OUT_W+15:16];

endmodule
`default_nettype wire

// ===== design/sta_align.sv =====
// sync window, zero points, resync request and stamp decision
`default_nettype none
module sta_align
  import sta_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_acc,
  input  wire logic              kind,
  input  wire logic [TIME_W-1:0] host_time,
  input  wire logic [TIME_W-1:0] device_time,
  input  wire sta_cfg_t          cfg,
  output sta_ctrl_t              ctrl
);

  logic              first_seen_r, first_seen_nxt;
  logic              sync_pending_r, sync_pending_nxt;
  logic              enabled_r, enabled_nxt;
  logic [TIME_W-1:0] last_arrival_r, last_arrival_nxt;
  logic [TIME_W-1:0] host_zero_r, host_zero_nxt;
  logic [TIME_W-1:0] offset_r, offset_nxt;
  logic [TIME_W-1:0] latest_dev_r, latest_dev_nxt;
  logic [TIME_W-1:0] last_stamp_r, last_stamp_nxt;
  logic [INTERVAL_W:0] win_lo, win_hi;

  logic              is_sample, active;
  logic [TIME_W:0]   gap, since_zero;
  logic              sync_hit, resync_due;
  logic [TIME_W-1:0] base_dev, stamp;
  logic              want_pub, pub;

  assign win_lo = {1'b0, cfg.data_interval} - {1'b0, cfg.window_epsilon};
  assign win_hi = {1'b0, cfg.data_interval} + {1'b0, cfg.window_epsilon};

  assign is_sample  = item_acc && (kind == KIND_SAMPLE);
  assign active     = is_sample && first_seen_r;
  assign gap        = {1'b0, host_time} - {1'b0, last_arrival_r};
  assign since_zero = {1'b0, host_time} - {1'b0, host_zero_r};

  // signed gap against lo (may be negative) and hi
  assign sync_hit = active && sync_pending_r
                 && ($signed(gap) >= $signed({{(TIME_W-INTERVAL_W){win_lo[INTERVAL_W]}},
                                              win_lo}))
                 && ($signed(gap) <= $signed({{(TIME_W-INTERVAL_W){1'b0}}, win_hi}));

  // on a sync hit the zero point is now, so no resync can be due
  assign resync_due = active && !sync_hit && (cfg.resync_interval != '0)
                   && !since_zero[TIME_W]
                   && (since_zero[TIME_W-1:0] >= {{(TIME_W-RESYNC_W){1'b0}},
                                                  cfg.resync_interval});

  assign base_dev = (kind == KIND_TICK) ? latest_dev_r : device_time;
  assign stamp    = sync_hit ? host_time : base_dev + offset_r;

  always_comb begin
    want_pub = 1'b0;
    if (item_acc) begin
      if (kind == KIND_TICK) begin
        want_pub = cfg.on_tick && enabled_r;
      end else begin
        want_pub = active && (enabled_r || sync_hit) && !cfg.on_tick;
      end
    end
  end

  assign pub = want_pub && (stamp >= last_stamp_r);

  always_comb begin
    first_seen_nxt   = first_seen_r;
    sync_pending_nxt = sync_pending_r;
    enabled_nxt      = enabled_r;
    last_arrival_nxt = last_arrival_r;
    host_zero_nxt    = host_zero_r;
    offset_nxt       = offset_r;
    latest_dev_nxt   = latest_dev_r;
    last_stamp_nxt   = pub ? stamp : last_stamp_r;
    if (is_sample) begin
      first_seen_nxt   = 1'b1;
      last_arrival_nxt = host_time;
    end
    if (sync_hit) begin
      host_zero_nxt    = host_time;
      offset_nxt       = host_time - device_time;
      sync_pending_nxt = 1'b0;
      enabled_nxt      = 1'b1;
    end
    if (resync_due) begin
      sync_pending_nxt = 1'b1;
    end
    if (active && (enabled_r || sync_hit)) begin
      latest_dev_nxt = device_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_seen_r   <= 1'b0;
      sync_pending_r <= 1'b1;
      enabled_r      <= 1'b0;
      last_arrival_r <= '0;
      host_zero_r    <= '0;
      offset_r       <= '0;
      latest_dev_r   <= '0;
      last_stamp_r   <= '0;
    end else begin
      first_seen_r   <= first_seen_nxt;
      sync_pending_r <= sync_pending_nxt;
      enabled_r      <= enabled_nxt;
      last_arrival_r <= last_arrival_nxt;
      host_zero_r    <= host_zero_nxt;
      offset_r       <= offset_nxt;
      latest_dev_r   <= latest_dev_nxt;
      last_stamp_r   <= last_stamp_nxt;
    end
  end

  assign ctrl.publish    = pub;
  assign ctrl.load_axes  = active && (enabled_r || sync_hit);
  assign ctrl.use_latest = (kind == KIND_TICK);
  assign ctrl.stamp      = stamp;

  a_enabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
    enabled_r |=> enabled_r) else $error("output enable dropped");

  a_pub_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    pub |-> enabled_nxt) else $error("item published before sync");

  a_no_hit_first: assert property (@(posedge clk) disable iff (!rst_n)
    !first_seen_r |-> !sync_hit) else $error("sync on first sample");

endmodule
`default_nettype wire

// ===== design/sensor_timestamp_aligner.sv =====
// top level: config registers, axis lanes, alignment control and output register
//
//  channel | ports                                   | direction
//  input   | in_valid, in_stall, in_kind, in_*_ns,   | item in
//          | in_accel_{x,y,z}_in                      |
//  output  | out_valid, out_stall, out_stamp_ns,      | item out
//          | out_accel_{x,y,z}_out                    |
//  config  | cfg_we, cfg_index, cfg_data              | register write
//
// one item per unstalled cycle; a published item appears in the output register
// the cycle after it is taken, set by one state update and stamp add/compare
// reset is synchronous; the block takes items directly after reset
// in_stall is high only while a result sits in the output register and
// out_stall holds it there
`default_nettype none
module sensor_timestamp_aligner
  import sta_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_kind,
  input  wire logic [TIME_W-1:0]             in_host_time_ns,
  input  wire logic [TIME_W-1:0]             in_device_time_ns,
  input  wire logic signed [AXIS_IN_W-1:0]   in_accel_x_in,
  input  wire logic signed [AXIS_IN_W-1:0]   in_accel_y_in,
  input  wire logic signed [AXIS_IN_W-1:0]   in_accel_z_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [TIME_W-1:0]                  out_stamp_ns,
  output logic signed [AXIS_OUT_W-1:0]       out_accel_x_out,
  output logic signed [AXIS_OUT_W-1:0]       out_accel_y_out,
  output logic signed [AXIS_OUT_W-1:0]       out_accel_z_out,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  sta_cfg_t  cfg_r;
  sta_ctrl_t ctrl;
  logic      item_acc;
  logic      out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0] out_stamp_r;

  logic signed [AXIS_IN_W-1:0]  axis_in   [NUM_AXES];
  logic signed [AXIS_OUT_W-1:0] axis_scl  [NUM_AXES];
  logic signed [AXIS_OUT_W-1:0] latest_r  [NUM_AXES];
  logic signed [AXIS_OUT_W-1:0] out_axis_r [NUM_AXES];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_interval   <= DATA_INTERVAL_RST;
      cfg_r.window_epsilon  <= WINDOW_EPSILON_RST;
      cfg_r.resync_interval <= RESYNC_RST;
      cfg_r.on_tick         <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DATA_INTERVAL:   cfg_r.data_interval   <= cfg_data[INTERVAL_W-1:0];
        CFG_WINDOW_EPSILON:  cfg_r.window_epsilon  <= cfg_data[INTERVAL_W-1:0];
        CFG_RESYNC_INTERVAL: cfg_r.resync_interval <= cfg_data[RESYNC_W-1:0];
        CFG_PUBLISH_ON_TICK: cfg_r.on_tick         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = out_valid_r && out_stall;
  assign item_acc = in_valid && !in_stall;

  assign axis_in[0] = in_accel_x_in;
  assign axis_in[1] = in_accel_y_in;
  assign axis_in[2] = in_accel_z_in;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    sta_axis_lane u_lane (
      .axis_in  (axis_in[i]),
      .axis_out (axis_scl[i])
    );
  end

  sta_align u_align (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_acc    (item_acc),
    .kind        (in_kind),
    .host_time   (in_host_time_ns),
    .device_time (in_device_time_ns),
    .cfg         (cfg_r),
    .ctrl        (ctrl)
  );

  // latest scaled axes and the merged output payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (!rst_n) begin
        latest_r[i] <= '0;
      end else if (ctrl.load_axes) begin
        latest_r[i] <= axis_scl[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.publish) begin
      out_stamp_r <= ctrl.stamp;
      for (int i = 0; i < NUM_AXES; i++) begin
        out_axis_r[i] <= ctrl.use_latest ? latest_r[i] : axis_scl[i];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.publish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_stamp_ns    = out_stamp_r;
  assign out_accel_x_out = out_axis_r[0];
  assign out_accel_y_out = out_axis_r[1];
  assign out_accel_z_out = out_axis_r[2];

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r) else $error("input stalled with empty output register");

  a_pub_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.publish |=> out_valid_r) else $error("published item not presented");

  a_pub_only_taken: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.publish |-> item_acc) else $error("publish without a taken item");

endmodule
`default_nettype wire
